[sv/rwpg_pkg.sv]
`default_nettype none

package rwpg_pkg;

  localparam int MAX_LEDS_DEF       = 1024;
  localparam int FRAMES_PER_RUN_DEF = 1280;

  localparam int LED_COUNT_W = 11;
  localparam int LEVEL_W     = 10;
  localparam int CH_W        = 8;
  localparam int PIX_IDX_W   = 10;
  localparam int PROD_W      = CH_W + LEVEL_W;
  localparam int SCALED_W    = PROD_W - 7;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 14;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [LEVEL_W-1:0]     FULL_LEVEL = LEVEL_W'(640);
  localparam logic [PROD_W-1:0]      HALF_LEVEL = PROD_W'(320);
  localparam logic [RECIP_W-1:0]     RECIP_5    = RECIP_W'(3277);
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = LED_COUNT_W'(60);

  localparam logic [CH_W-1:0] CH_MAX   = 8'd255;
  localparam logic [CH_W-1:0] SEG_ONE  = 8'd85;
  localparam logic [CH_W-1:0] SEG_TWO  = 8'd170;
  localparam logic [CH_W-1:0] RAMP_MUL = 8'd3;

  typedef enum logic [1:0] {
    REG_LED_COUNT = 2'd0,
    REG_BREATHING = 2'd1,
    REG_FIXED_LVL = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LED_COUNT_W-1:0] led_count;
    logic                   breathing_enable;
    logic [LEVEL_W-1:0]     fixed_level;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAP,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic map;
    logic scale;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[sv/rwpg_cfg.sv]
`default_nettype none

module rwpg_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [rwpg_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [rwpg_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [rwpg_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                    cfg_pready,
  output rwpg_pkg::cfg_t                          cfg
);
  import rwpg_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count        <= LED_COUNT_RST;
      cfg_r.breathing_enable <= 1'b0;
      cfg_r.fixed_level      <= FULL_LEVEL;
    end else if (wr_en) begin
      unique case (idx)
        REG_LED_COUNT: cfg_r.led_count        <= cfg_pwdata[LED_COUNT_W-1:0];
        REG_BREATHING: cfg_r.breathing_enable <= cfg_pwdata[0];
        REG_FIXED_LVL: cfg_r.fixed_level      <= cfg_pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LED_COUNT: cfg_prdata = CFG_DATA_W'(cfg_r.led_count);
      REG_BREATHING: cfg_prdata = CFG_DATA_W'(cfg_r.breathing_enable);
      REG_FIXED_LVL: cfg_prdata = CFG_DATA_W'(cfg_r.fixed_level);
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/rwpg_ctrl.sv]
`default_nettype none

module rwpg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire rwpg_pkg::status_t status,
  output rwpg_pkg::cmd_t         cmd
);
  import rwpg_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/rwpg_dp.sv]
`default_nettype none

module rwpg_dp #(
  parameter int MAX_LEDS       = rwpg_pkg::MAX_LEDS_DEF,
  parameter int FRAMES_PER_RUN = rwpg_pkg::FRAMES_PER_RUN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rwpg_pkg::cfg_t                    cfg,
  input  wire rwpg_pkg::cmd_t                    cmd,
  output rwpg_pkg::status_t                      status,
  input  wire logic                              restart,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [rwpg_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tlast
);
  import rwpg_pkg::*;

  localparam int PW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int NW   = $clog2(MAX_LEDS + 1);
  localparam int EW   = (NW > LED_COUNT_W) ? NW : LED_COUNT_W;
  localparam int FW   = $clog2(FRAMES_PER_RUN);
  localparam int FXW  = (FW > CH_W) ? FW : CH_W;
  localparam int DV   = PW + CH_W;
  localparam int DCW  = $clog2(DV);
  localparam int RPW  = SCALED_W + RECIP_W;

  logic [PW-1:0]      pixel_r;
  logic [FW-1:0]      frame_r;
  logic [LEVEL_W-1:0] level_r;
  logic               ramp_down_r;

  logic [NW-1:0]  rem_r;
  logic [DV-1:0]  dvd_r;
  logic [CH_W-1:0] q_r;
  logic [DCW-1:0] cnt_r;

  logic [PROD_W-1:0] prod_r [3];
  logic [CH_W-1:0]   chan_r [3];

  logic               out_valid_r;
  logic [PIX_IDX_W-1:0] out_pix_r;
  logic [CH_W-1:0]    out_red_r;
  logic [CH_W-1:0]    out_green_r;
  logic [CH_W-1:0]    out_blue_r;
  logic               out_last_r;

  logic [NW-1:0]      n_eff;
  logic [EW-1:0]      led_ext;
  logic [PW-1:0]      pix_start;
  logic [FW-1:0]      frame_start;
  logic [LEVEL_W-1:0] fixed_sat;
  logic [NW:0]        trial;
  logic               ge;
  logic [FXW-1:0]     frame_ext;
  logic [CH_W-1:0]    pos;
  logic [CH_W-1:0]    off;
  logic [CH_W-1:0]    colour [3];
  logic               last;

  assign led_ext = EW'(cfg.led_count);

  always_comb begin
    if (cfg.led_count == '0) begin
      n_eff = NW'(1);
    end else if (led_ext > EW'(MAX_LEDS)) begin
      n_eff = NW'(MAX_LEDS);
    end else begin
      n_eff = NW'(led_ext);
    end
  end

  assign pix_start   = restart ? '0 : pixel_r;
  assign frame_start = restart ? '0 : frame_r;
  assign fixed_sat   = (cfg.fixed_level > FULL_LEVEL) ? FULL_LEVEL : cfg.fixed_level;

  // restoring division step
  assign trial = {rem_r, dvd_r[DV-1]};
  assign ge    = trial >= {1'b0, n_eff};

  assign status.div_done = cnt_r == DCW'(DV - 1);
  assign status.out_free = !out_valid_r || out_tready;

  // wheel position and colour segments
  assign frame_ext = FXW'(frame_r);
  assign pos       = q_r + frame_ext[CH_W-1:0];

  always_comb begin
    if (pos < SEG_ONE) begin
      off       = pos;
      colour[0] = off * RAMP_MUL;
      colour[1] = CH_MAX - off * RAMP_MUL;
      colour[2] = '0;
    end else if (pos < SEG_TWO) begin
      off       = pos - SEG_ONE;
      colour[0] = CH_MAX - off * RAMP_MUL;
      colour[1] = '0;
      colour[2] = off * RAMP_MUL;
    end else begin
      off       = pos - SEG_TWO;
      colour[0] = '0;
      colour[1] = off * RAMP_MUL;
      colour[2] = CH_MAX - off * RAMP_MUL;
    end
  end

  assign last = (NW+1)'(pixel_r) + (NW+1)'(1) >= (NW+1)'(n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_r     <= '0;
      frame_r     <= '0;
      level_r     <= FULL_LEVEL;
      ramp_down_r <= 1'b0;
    end else if (cmd.accept) begin
      pixel_r <= pix_start;
      frame_r <= frame_start;
      if (pix_start == '0 && frame_start == '0) begin
        level_r <= cfg.breathing_enable ? '0 : fixed_sat;
      end
    end else if (cmd.finish) begin
      if (last) begin
        pixel_r <= '0;
        if (cfg.breathing_enable) begin
          if (ramp_down_r) begin
            if (level_r <= LEVEL_W'(1)) begin
              level_r     <= '0;
              ramp_down_r <= 1'b0;
            end else begin
              level_r <= level_r - LEVEL_W'(1);
            end
          end else begin
            if (level_r + LEVEL_W'(1) >= FULL_LEVEL) begin
              level_r     <= FULL_LEVEL;
              ramp_down_r <= 1'b1;
            end else begin
              level_r <= level_r + LEVEL_W'(1);
            end
          end
        end
        if ((FW+1)'(frame_r) + (FW+1)'(1) >= (FW+1)'(FRAMES_PER_RUN)) begin
          frame_r <= '0;
        end else begin
          frame_r <= frame_r + FW'(1);
        end
      end else begin
        pixel_r <= pixel_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.accept) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dvd_r <= {pix_start, {CH_W{1'b0}}};
      rem_r <= '0;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DV-2:0], 1'b0};
      rem_r <= ge ? NW'(trial - {1'b0, n_eff}) : trial[NW-1:0];
      q_r   <= {q_r[CH_W-2:0], ge};
    end
  end

  // channel scaling: (c * level + 320) / 640, divide by 5 via reciprocal
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.map) begin
        prod_r[i] <= PROD_W'(colour[i]) * PROD_W'(level_r);
      end
      if (cmd.scale) begin
        chan_r[i] <= CH_W'((RPW'(SCALED_W'((prod_r[i] + HALF_LEVEL) >> 7)) * RPW'(RECIP_5))
                           >> RECIP_SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pix_r   <= PIX_IDX_W'(pixel_r);
      out_red_r   <= chan_r[0];
      out_green_r <= chan_r[1];
      out_blue_r  <= chan_r[2];
      out_last_r  <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - PIX_IDX_W - 3*CH_W){1'b0}},
                       out_blue_r, out_green_r, out_red_r, out_pix_r};

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= FULL_LEVEL)
    else $error("brightness level above full scale");

  a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (FW+1)'(frame_r) < (FW+1)'(FRAMES_PER_RUN))
    else $error("frame counter beyond run length");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < n_eff)
    else $error("divider remainder not below led count");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished pixel not presented");
`endif

endmodule

`default_nettype wire

[sv/rainbow_wheel_pixel_generator.sv]
// rainbow wheel pixel generator, one pixel colour per input transaction
// an accepted input passes the divider, map, scale and out states, then the output register
// no new input is taken until the pixel leaves the out state; the pace is set
// by the bit-serial divider for pixel*256/led_count, one quotient bit a cycle
// output register lets the next transaction start while a result waits
// reset (synchronous, active low): counters to pixel 0 frame 0, registers to defaults
`default_nettype none

module rainbow_wheel_pixel_generator #(
  parameter int MAX_LEDS       = rwpg_pkg::MAX_LEDS_DEF,
  parameter int FRAMES_PER_RUN = rwpg_pkg::FRAMES_PER_RUN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [0] restart
  input  wire logic [rwpg_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [9:0] pixel_index, [17:10] red, [25:18] green, [33:26] blue
  output logic [rwpg_pkg::OUT_DATA_W-1:0]        out_tdata,
  // frame_end
  output logic                                   out_tlast,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [rwpg_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [rwpg_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [rwpg_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);
  import rwpg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  rwpg_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rwpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rwpg_dp #(
    .MAX_LEDS       (MAX_LEDS),
    .FRAMES_PER_RUN (FRAMES_PER_RUN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .restart    (in_tdata[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[dv/rainbow_wheel_pixel_generator_test.sv]
`timescale 1ns / 100ps

module rainbow_wheel_pixel_generator_test;
  import rwpg_pkg::*;

  localparam int FULL_LVL   = int'(FULL_LEVEL);
  localparam int HOLD_PHASE = 9;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic                 frame_end;
  } pixel_colour_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  bit            pending_restarts[$];
  pixel_colour_t expected_colours[$];
  int            fail_count = 0;
  int            phase_no = 0;
  int            idle_mode = 0;
  logic          hold_off = 1'b0;

  // register copies and animation state
  int unsigned led_count_reg = 60;
  int unsigned breathing_reg = 0;
  int unsigned fixed_level_reg = FULL_LVL;
  int unsigned pixel_ctr = 0;
  int unsigned frame_ctr = 0;
  int unsigned bright_level = FULL_LVL;
  int unsigned ramping_down = 0;

  rainbow_wheel_pixel_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void queue_restart(input bit restart);
    pending_restarts = {pending_restarts, restart};
  endfunction

  function automatic void queue_colour(input pixel_colour_t px);
    expected_colours = {expected_colours, px};
  endfunction

  function automatic int unsigned scale_channel(input int unsigned c);
    return (c * bright_level + FULL_LVL / 2) / FULL_LVL;
  endfunction

  function automatic pixel_colour_t next_pixel_colour(input bit restart);
    int unsigned n;
    int unsigned wheel;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    bit          last;
    pixel_colour_t px;
    n = led_count_reg;
    if (n == 0) n = 1;
    if (n > MAX_LEDS_DEF) n = MAX_LEDS_DEF;
    if (restart) begin
      pixel_ctr = 0;
      frame_ctr = 0;
    end
    if (pixel_ctr == 0 && frame_ctr == 0) begin
      if (breathing_reg != 0) bright_level = 0;
      else bright_level = (fixed_level_reg > FULL_LVL) ? FULL_LVL : fixed_level_reg;
    end
    wheel = ((pixel_ctr * 256) / n + frame_ctr) % 256;
    if (wheel < 85) begin
      r = wheel * 3;
      g = 255 - wheel * 3;
      b = 0;
    end else if (wheel < 170) begin
      wheel = wheel - 85;
      r = 255 - wheel * 3;
      g = 0;
      b = wheel * 3;
    end else begin
      wheel = wheel - 170;
      r = 0;
      g = wheel * 3;
      b = 255 - wheel * 3;
    end
    last = (pixel_ctr + 1 >= n);
    px.pixel_index = PIX_IDX_W'(pixel_ctr);
    px.red         = CH_W'(scale_channel(r));
    px.green       = CH_W'(scale_channel(g));
    px.blue        = CH_W'(scale_channel(b));
    px.frame_end   = last;
    if (last) begin
      pixel_ctr = 0;
      if (breathing_reg != 0) begin
        if (ramping_down != 0) begin
          if (bright_level <= 1) begin
            bright_level = 0;
            ramping_down = 0;
          end else begin
            bright_level = bright_level - 1;
          end
        end else begin
          if (bright_level + 1 >= FULL_LVL) begin
            bright_level = FULL_LVL;
            ramping_down = 1;
          end else begin
            bright_level = bright_level + 1;
          end
        end
      end
      frame_ctr = (frame_ctr + 1 >= FRAMES_PER_RUN_DEF) ? 0 : frame_ctr + 1;
    end else begin
      pixel_ctr = pixel_ctr + 1;
    end
    return px;
  endfunction

  function automatic bit sender_pauses();
    int pct;
    pct = (idle_mode == 1) ? 66 : (idle_mode == 3) ? 37 : 0;
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit receiver_stalls();
    int pct;
    pct = (idle_mode == 2) ? 66 : (idle_mode == 3) ? 37 : 0;
    return $urandom_range(99) < pct;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) queue_colour(next_pixel_colour(in_tdata[0]));
      if (!in_tvalid || in_tready) begin
        if (pending_restarts.size() > 0 && !sender_pauses()) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_DATA_W'(pending_restarts.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    pixel_colour_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_colours.size() == 0) begin
          $error("pixel transaction with no colour pending: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_colours.pop_front();
          if (out_tdata[9:0] !== want.pixel_index) begin
            $error("pixel_index: expected %0d, got %0d", want.pixel_index, out_tdata[9:0]);
            fail_count++;
          end
          if (out_tdata[17:10] !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_tdata[17:10]);
            fail_count++;
          end
          if (out_tdata[25:18] !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_tdata[25:18]);
            fail_count++;
          end
          if (out_tdata[33:26] !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_tdata[33:26]);
            fail_count++;
          end
          if (out_tlast !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_tlast);
            fail_count++;
          end
        end
      end
      out_tready <= !hold_off && !receiver_stalls();
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (phase_no == HOLD_PHASE);
    repeat (30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LED_COUNT: led_count_reg   = value & 32'h7FF;
      REG_BREATHING: breathing_reg   = value & 32'h1;
      REG_FIXED_LVL: fixed_level_reg = value & 32'h3FF;
      default: ;
    endcase
  endtask

  task automatic run_phase(input int unsigned leds, input int unsigned breathe,
                           input int unsigned lvl, input int count,
                           input bit first_restart, input int restart_pct, input int mode);
    write_reg(REG_LED_COUNT, leds);
    write_reg(REG_BREATHING, breathe);
    write_reg(REG_FIXED_LVL, lvl);
    idle_mode = mode;
    phase_no++;
    for (int i = 0; i < count; i++)
      queue_restart((i == 0) ? first_restart : ($urandom_range(99) < restart_pct));
    do @(posedge clk);
    while (pending_restarts.size() > 0 || in_tvalid || expected_colours.size() > 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic int unsigned pick_led_count();
    case ($urandom_range(9))
      0: return 0;
      1: return 2047;
      2: return 1024;
      3: return $urandom_range(13, 2047);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset
    idle_mode = 0;
    for (int i = 0; i < 3; i++) queue_restart(1'b0);
    do @(posedge clk);
    while (pending_restarts.size() > 0 || in_tvalid || expected_colours.size() > 0);
    repeat (30) @(posedge clk);

    // zero count, level above full scale
    run_phase(0, 0, 1023, 2, 1'b1, 0, 0);
    // count above the maximum, dark level
    run_phase(2047, 0, 0, 3, 1'b1, 0, 1);
    // count lowered mid-frame leaves the pixel counter beyond the strip
    run_phase(10, 0, 321, 6, 1'b1, 0, 2);
    run_phase(3, 0, 321, 2, 1'b0, 0, 3);
    run_phase(1, 1, 640, 4, 1'b1, 0, 0);

    // breathing ramp past the top, breathing off mid-run,
    // then a new run while still ramping down
    run_phase(1, 1, $urandom_range(1023), 646, 1'b1, 0, 0);
    run_phase(1, 0, $urandom_range(1023), 4, 1'b0, 0, 3);
    run_phase(1, 1, $urandom_range(1023), 4, 1'b1, 0, 1);

    // the longest strip, with the long hold-off
    run_phase(1024, $urandom_range(1), $urandom_range(1023), 230, 1'b1, 0, 0);

    for (int k = 0; k < 10; k++)
      run_phase(pick_led_count(), $urandom_range(1), $urandom_range(1023),
                25, $urandom_range(1), 6, k % 4);

    repeat (60) @(posedge clk);
    if (expected_colours.size() > 0) begin
      $error("%0d colours never came out", expected_colours.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
